### rtl/icmp_probe_reply_classifier_assert.svh
// Assertion macros used by the classifier top level.
`ifndef ICMP_PROBE_REPLY_CLASSIFIER_ASSERT_SVH
`define ICMP_PROBE_REPLY_CLASSIFIER_ASSERT_SVH

// Combinational property checked at every clock edge outside reset.
`define ICPR_ASSERT_COMB(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ICPR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/icpr_pkg.sv
// Shared types and constants for the ICMP probe reply classifier.
package icpr_pkg;

    localparam logic [2:0] VERDICT_IGNORED  = 3'd0;
    localparam logic [2:0] VERDICT_TIMXCEED = 3'd1;
    localparam logic [2:0] VERDICT_DEST     = 3'd2;
    localparam logic [2:0] VERDICT_UNREACH  = 3'd3;
    localparam logic [2:0] VERDICT_TIMEOUT  = 3'd4;

    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] CODE_INTRANS       = 8'd0;
    localparam logic [7:0] CODE_PORT          = 8'd3;
    localparam logic [7:0] PROTO_UDP          = 8'd17;

    localparam logic [1:0] REG_SRC_PORT  = 2'd0;
    localparam logic [1:0] REG_BASE_PORT = 2'd1;
    localparam logic [1:0] REG_PROBE_SEQ = 2'd2;
    localparam logic [1:0] REG_TIMEOUT   = 2'd3;

    localparam logic [15:0] RST_BASE_PORT = 16'd33434;
    localparam logic [31:0] RST_TIMEOUT   = 32'd3;

    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] base_dst_port;
        logic [15:0] probe_seq;
        logic [31:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] msg_type;
        logic [7:0] msg_code;
    } t_result;

endpackage

### rtl/icpr_front.sv
// Front end: byte capture, packet classification and tick timeout.
module icpr_front #(
    parameter int MAX_PKT_BYTES = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  icpr_pkg::t_cfg   i_cfg,
    input  logic             i_accept,
    input  logic             i_req_type,
    input  logic [7:0]       i_pkt_byte,
    input  logic             i_is_last,
    output logic             o_push,
    output icpr_pkg::t_result o_res
);
    import icpr_pkg::*;

    localparam int BW = $clog2(MAX_PKT_BYTES + 1);
    localparam int CW = (BW > 8) ? BW : 8;

    logic [BW-1:0] r_idx, n_idx;
    logic [5:0]    r_outer, n_outer, r_inner, n_inner;
    logic [7:0]    r_type, n_type, r_code, n_code, r_proto, n_proto;
    logic [15:0]   r_sport, n_sport, r_dport, n_dport;
    logic [31:0]   r_ticks, n_ticks;

    logic          cap;
    logic [CW-1:0] idx_c, pos_inner, pos_ports, len_c, outer_c, inner_c;
    logic [5:0]    hl_new, outer_eff, inner_eff;
    logic [31:0]   tick_inc;
    logic          valid_hdr, type_ok, len_ok, match;
    logic [2:0]    verdict;
    logic [15:0]   exp_dport;

    always_comb begin
        cap       = (r_idx < BW'(MAX_PKT_BYTES));
        idx_c     = CW'(r_idx);
        hl_new    = {i_pkt_byte[3:0], 2'b00};
        outer_eff = (cap && r_idx == '0) ? hl_new : r_outer;
        pos_inner = CW'(outer_eff) + CW'(8);
        inner_eff = (cap && idx_c == pos_inner) ? hl_new : r_inner;
        pos_ports = pos_inner + CW'(inner_eff);

        n_outer = outer_eff;
        n_inner = inner_eff;
        n_type  = (cap && idx_c == CW'(outer_eff)) ? i_pkt_byte : r_type;
        n_code  = (cap && idx_c == CW'(outer_eff) + CW'(1)) ? i_pkt_byte : r_code;
        n_proto = (cap && idx_c == pos_inner + CW'(9)) ? i_pkt_byte : r_proto;
        n_sport = r_sport;
        n_dport = r_dport;
        if (cap && idx_c == pos_ports)            n_sport[15:8] = i_pkt_byte;
        if (cap && idx_c == pos_ports + CW'(1))   n_sport[7:0]  = i_pkt_byte;
        if (cap && idx_c == pos_ports + CW'(2))   n_dport[15:8] = i_pkt_byte;
        if (cap && idx_c == pos_ports + CW'(3))   n_dport[7:0]  = i_pkt_byte;
        n_idx = cap ? r_idx + BW'(1) : r_idx;

        // classify on post-capture values
        len_c     = CW'(n_idx);
        outer_c   = CW'(n_outer);
        inner_c   = CW'(n_inner);
        exp_dport = i_cfg.base_dst_port + i_cfg.probe_seq;
        valid_hdr = (len_c >= outer_c + CW'(8));
        type_ok   = (n_type == TYPE_TIME_EXCEEDED && n_code == CODE_INTRANS) ||
                    (n_type == TYPE_DEST_UNREACH);
        len_ok    = (len_c >= outer_c + CW'(28)) &&
                    (len_c >= outer_c + inner_c + CW'(12));
        match     = (n_proto == PROTO_UDP) && (n_sport == i_cfg.src_port) &&
                    (n_dport == exp_dport);
        if (!(valid_hdr && type_ok && len_ok && match)) begin
            verdict = VERDICT_IGNORED;
        end else if (n_type == TYPE_TIME_EXCEEDED) begin
            verdict = VERDICT_TIMXCEED;
        end else if (n_code == CODE_PORT) begin
            verdict = VERDICT_DEST;
        end else begin
            verdict = VERDICT_UNREACH;
        end

        tick_inc = (r_ticks == '1) ? r_ticks : r_ticks + 32'd1;
        n_ticks  = r_ticks;
        o_push   = 1'b0;
        o_res    = '0;
        if (i_accept) begin
            if (i_req_type) begin
                n_ticks = tick_inc;
                if (tick_inc >= i_cfg.timeout_ticks) begin
                    n_ticks       = '0;
                    o_push        = 1'b1;
                    o_res.verdict = VERDICT_TIMEOUT;
                end
            end else if (i_is_last) begin
                o_push         = 1'b1;
                o_res.verdict  = verdict;
                o_res.msg_type = valid_hdr ? n_type : 8'd0;
                o_res.msg_code = valid_hdr ? n_code : 8'd0;
                if (verdict != VERDICT_IGNORED) n_ticks = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_outer <= '0;
            r_inner <= '0;
            r_type  <= '0;
            r_code  <= '0;
            r_proto <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_ticks <= '0;
        end else begin
            r_ticks <= n_ticks;
            if (i_accept && !i_req_type) begin
                if (i_is_last) begin
                    r_idx   <= '0;
                    r_outer <= '0;
                    r_inner <= '0;
                    r_type  <= '0;
                    r_code  <= '0;
                    r_proto <= '0;
                    r_sport <= '0;
                    r_dport <= '0;
                end else begin
                    r_idx   <= n_idx;
                    r_outer <= n_outer;
                    r_inner <= n_inner;
                    r_type  <= n_type;
                    r_code  <= n_code;
                    r_proto <= n_proto;
                    r_sport <= n_sport;
                    r_dport <= n_dport;
                end
            end
        end
    end

endmodule

### rtl/icpr_fifo.sv
// Two-entry result queue between front and back.
module icpr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  icpr_pkg::t_result i_data,
    input  logic              i_pop,
    output icpr_pkg::t_result o_data,
    output logic              o_empty,
    output logic              o_full
);
    import icpr_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### rtl/icpr_back.sv
// Back end: output register that presents queued results.
module icpr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  icpr_pkg::t_result i_data,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output icpr_pkg::t_result o_res
);
    import icpr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_data;
    end

endmodule

### rtl/icmp_probe_reply_classifier.sv
// Top level of the traceroute ICMPv4 reply classifier.
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------
//  request   i_valid / o_ready    i_req_type, i_pkt_byte, i_is_last
//  verdict   o_valid / i_ready    o_verdict, o_msg_type, o_msg_code
//  config    i_cfg_we             i_cfg_idx, i_cfg_data (no wait, no read)
//
// One request transaction per cycle while o_ready is high; each byte or
// tick is handled in the cycle it is accepted, bounded by the capture
// compare and classify path. A verdict is written to the queue at the
// accepting edge and then passes through the output register to o_valid.
// Reset is synchronous, active low, and clears captures, tick count,
// queue and registers (base port 33434, timeout 3 ticks).
// o_ready drops only when the two-entry queue is full.
module icmp_probe_reply_classifier #(
    parameter int MAX_PKT_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_pkt_byte,
    input  logic        i_is_last,
    // verdict channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_verdict,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_msg_code,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import icpr_pkg::*;

    `include "icmp_probe_reply_classifier_assert.svh"

    t_cfg    r_cfg;
    t_result w_push_res, w_q_res, w_out_res;
    logic    w_accept, w_push, w_pop, w_empty, w_full;

    // config registers; unused upper data bits are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_port      <= '0;
            r_cfg.base_dst_port <= RST_BASE_PORT;
            r_cfg.probe_seq     <= '0;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_PORT:  r_cfg.src_port      <= i_cfg_data[15:0];
                REG_BASE_PORT: r_cfg.base_dst_port <= i_cfg_data[15:0];
                REG_PROBE_SEQ: r_cfg.probe_seq     <= i_cfg_data[15:0];
                REG_TIMEOUT:   r_cfg.timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front stalls only on a full queue
    assign o_ready  = !w_full;
    assign w_accept = i_valid && o_ready;

    icpr_front #(
        .MAX_PKT_BYTES (MAX_PKT_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (w_accept),
        .i_req_type (i_req_type),
        .i_pkt_byte (i_pkt_byte),
        .i_is_last  (i_is_last),
        .o_push     (w_push),
        .o_res      (w_push_res)
    );

    icpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_res),
        .i_pop   (w_pop),
        .o_data  (w_q_res),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    icpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_q_res),
        .o_pop   (w_pop),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_res   (w_out_res)
    );

    assign o_verdict  = w_out_res.verdict;
    assign o_msg_type = w_out_res.msg_type;
    assign o_msg_code = w_out_res.msg_code;

    // every accepted last byte yields exactly one queued verdict
    `ICPR_ASSERT_IMPL(a_last_pushes, w_accept && !i_req_type && i_is_last, w_push, "last byte without verdict")
    // a timeout verdict never carries ICMP type or code
    `ICPR_ASSERT_IMPL(a_timeout_zero, o_valid && o_verdict == VERDICT_TIMEOUT, o_msg_type == 8'd0 && o_msg_code == 8'd0, "timeout with nonzero type/code")
    // nothing is pushed into a full queue
    `ICPR_ASSERT_COMB(a_no_overflow, !(w_push && w_full), "push into full queue")

endmodule

### tb/icmp_probe_reply_classifier_tb.sv
// Self-checking testbench for the traceroute ICMP reply classifier: packets, ticks, verdicts.

typedef bit [7:0] t_octet_q[$];

// Request kinds carried on i_req_type.
localparam bit REQ_BYTE = 1'b0;
localparam bit REQ_TICK = 1'b1;

// Header geometry used by the capture points and the length checks.
localparam int ICMP_HDR_BYTES   = 8;
localparam int IP_MIN_HDR_BYTES = 20;
localparam int IP_PROTO_OFFSET  = 9;
localparam int UDP_PORT_BYTES   = 4;

// Mirrors the classifier state, queues the verdicts it predicts and checks the
// verdicts seen on the output channel in order.
class verdict_scoreboard;
    // register mirror
    bit [15:0] src_port;
    bit [15:0] base_port;
    bit [15:0] probe_seq;
    bit [31:0] timeout_ticks;
    // per-packet capture mirror
    int unsigned byte_idx;
    bit [5:0]  outer_len;
    bit [5:0]  inner_len;
    bit [7:0]  type_seen;
    bit [7:0]  code_seen;
    bit [7:0]  proto_seen;
    bit [15:0] quoted_sport;
    bit [15:0] quoted_dport;
    bit [31:0] tick_count;
    int unsigned pkt_limit;

    icpr_pkg::t_result verdict_q[$];
    int mismatches;
    int verdicts_checked;

    function new(int unsigned max_bytes);
        pkt_limit        = max_bytes;
        src_port         = '0;
        base_port        = icpr_pkg::RST_BASE_PORT;
        probe_seq        = '0;
        timeout_ticks    = icpr_pkg::RST_TIMEOUT;
        tick_count       = '0;
        mismatches       = 0;
        verdicts_checked = 0;
        clear_packet();
    endfunction

    function void clear_packet();
        byte_idx     = 0;
        outer_len    = '0;
        inner_len    = '0;
        type_seen    = '0;
        code_seen    = '0;
        proto_seen   = '0;
        quoted_sport = '0;
        quoted_dport = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            icpr_pkg::REG_SRC_PORT:  src_port      = data[15:0];
            icpr_pkg::REG_BASE_PORT: base_port     = data[15:0];
            icpr_pkg::REG_PROBE_SEQ: probe_seq     = data[15:0];
            icpr_pkg::REG_TIMEOUT:   timeout_ticks = data;
            default: ;
        endcase
    endfunction

    // Capture points move with the header lengths, so order matters: a byte
    // that sets a length is also compared against the new positions.
    function void capture_byte(int unsigned i, bit [7:0] b);
        int unsigned inner_at;
        int unsigned ports_at;
        if (i == 0) outer_len = {b[3:0], 2'b00};
        if (i == outer_len) type_seen = b;
        if (i == outer_len + 1) code_seen = b;
        inner_at = outer_len + ICMP_HDR_BYTES;
        if (i == inner_at) inner_len = {b[3:0], 2'b00};
        if (i == inner_at + IP_PROTO_OFFSET) proto_seen = b;
        ports_at = inner_at + inner_len;
        if (i == ports_at)     quoted_sport[15:8] = b;
        if (i == ports_at + 1) quoted_sport[7:0]  = b;
        if (i == ports_at + 2) quoted_dport[15:8] = b;
        if (i == ports_at + 3) quoted_dport[7:0]  = b;
    endfunction

    function void classify(int unsigned n, output bit [2:0] verdict, output bit hdr_ok);
        int unsigned icmp_len;
        bit [15:0]   want_dport;
        bit          probe_match;
        verdict = icpr_pkg::VERDICT_IGNORED;
        hdr_ok  = 1'b0;
        if (n < outer_len + ICMP_HDR_BYTES) return;
        hdr_ok   = 1'b1;
        icmp_len = n - outer_len;
        if (!((type_seen == icpr_pkg::TYPE_TIME_EXCEEDED &&
               code_seen == icpr_pkg::CODE_INTRANS) ||
              type_seen == icpr_pkg::TYPE_DEST_UNREACH)) return;
        if (icmp_len < ICMP_HDR_BYTES + IP_MIN_HDR_BYTES) return;
        if (icmp_len < ICMP_HDR_BYTES + inner_len + UDP_PORT_BYTES) return;
        want_dport  = base_port + probe_seq;
        probe_match = proto_seen == icpr_pkg::PROTO_UDP && quoted_sport == src_port &&
                      quoted_dport == want_dport;
        if (!probe_match) return;
        if (type_seen == icpr_pkg::TYPE_TIME_EXCEEDED)
            verdict = icpr_pkg::VERDICT_TIMXCEED;
        else if (code_seen == icpr_pkg::CODE_PORT)
            verdict = icpr_pkg::VERDICT_DEST;
        else
            verdict = icpr_pkg::VERDICT_UNREACH;
    endfunction

    // One accepted request transaction.
    function void note_request(bit req_kind, bit [7:0] b, bit is_last);
        icpr_pkg::t_result r;
        bit [2:0] verdict;
        bit       hdr_ok;
        if (req_kind == REQ_TICK) begin
            if (tick_count != '1) tick_count++;
            if (tick_count >= timeout_ticks) begin
                tick_count = '0;
                r.verdict  = icpr_pkg::VERDICT_TIMEOUT;
                r.msg_type = '0;
                r.msg_code = '0;
                verdict_q.push_back(r);
            end
            return;
        end
        if (byte_idx < pkt_limit) begin
            capture_byte(byte_idx, b);
            byte_idx++;
        end
        if (!is_last) return;
        classify(byte_idx, verdict, hdr_ok);
        r.verdict  = verdict;
        r.msg_type = hdr_ok ? type_seen : 8'd0;
        r.msg_code = hdr_ok ? code_seen : 8'd0;
        verdict_q.push_back(r);
        if (verdict != icpr_pkg::VERDICT_IGNORED) tick_count = '0;
        clear_packet();
    endfunction

    task report(string what);
        $display("ERROR [verdict #%0d] %s", verdicts_checked, what);
        mismatches++;
    endtask

    // One accepted verdict transaction.
    task check_verdict(logic [2:0] verdict, logic [7:0] msg_type, logic [7:0] msg_code);
        icpr_pkg::t_result want;
        if (verdict_q.size() == 0) begin
            report($sformatf("unexpected verdict %0d type %0d code %0d",
                             verdict, msg_type, msg_code));
        end else begin
            want = verdict_q.pop_front();
            if (verdict !== want.verdict)
                report($sformatf("verdict %0d, expected %0d", verdict, want.verdict));
            if (msg_type !== want.msg_type)
                report($sformatf("msg_type %0d, expected %0d", msg_type, want.msg_type));
            if (msg_code !== want.msg_code)
                report($sformatf("msg_code %0d, expected %0d", msg_code, want.msg_code));
        end
        verdicts_checked++;
    endtask

    task flush_check();
        icpr_pkg::t_result want;
        while (verdict_q.size() != 0) begin
            want = verdict_q.pop_front();
            report($sformatf("missing verdict %0d type %0d code %0d",
                             want.verdict, want.msg_type, want.msg_code));
        end
    endtask
endclass

module icmp_probe_reply_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import icpr_pkg::*;

    localparam int PKT_LIMIT      = 128;
    localparam int RANDOM_ITEMS   = 800;
    localparam int HOLD_CYCLES    = 60;   // long consumer stall in the pressure phase
    localparam int SETTLE_CYCLES  = 6;    // verdict shows after the queue and the output register
    localparam int CYCLE_LIMIT    = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_req_type;
    logic [7:0]  i_pkt_byte;
    logic        i_is_last;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_verdict;
    logic [7:0]  o_msg_type;
    logic [7:0]  o_msg_code;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    verdict_scoreboard sb;
    int  items_sent   = 0;
    int  cycle_count  = 0;
    bit  calm         = 1'b0;   // no idling on either side in the closing stretch
    bit  sender_gaps  = 1'b0;   // sender may insert idle bursts
    bit  hold_request = 1'b0;   // asks the consumer for one long stall

    icmp_probe_reply_classifier #(
        .MAX_PKT_BYTES(PKT_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_pkt_byte (i_pkt_byte),
        .i_is_last  (i_is_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_verdict  (o_verdict),
        .o_msg_type (o_msg_type),
        .o_msg_code (o_msg_code),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge; stimulus moves on the
    // falling edge, so every value seen here is settled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_request(i_req_type, i_pkt_byte, i_is_last);
            if (o_valid && i_ready)
                sb.check_verdict(o_verdict, o_msg_type, o_msg_code);
        end
    end

    // Consumer side: short random stalls, runs of steady ready, and one long
    // stall on request, counted here so the producer keeps pushing meanwhile.
    initial begin
        int held;
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                // acknowledge so the producer starts pushing into the stall
                hold_request = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            else
                @(negedge i_clk);
        end
    end

    // One request transaction. Valid stays up, payload steady, until o_ready
    // is seen at a rising edge; the next call changes it at the falling edge.
    task automatic send_item(bit req_kind, bit [7:0] b, bit is_last);
        @(negedge i_clk);
        if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req_kind;
        i_pkt_byte <= b;
        i_is_last  <= is_last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Byte and last mark ride along on a tick and must be ignored.
    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_packet(t_octet_q pkt, bit ticks_inside);
        foreach (pkt[k]) begin
            if (ticks_inside && $urandom_range(0, 15) == 0) send_tick();
            send_item(REQ_BYTE, pkt[k], k == pkt.size() - 1);
        end
    endtask

    // Only touched while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Stop offering, wait for every predicted verdict, then let the pipe settle
    // so a trailing tick or byte with no verdict is fully absorbed.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.verdict_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ICMP error carrying a quoted IP + UDP header. Length is at least what a
    // full quote needs; pad adds trailing payload.
    function automatic t_octet_q build_reply(bit [3:0] ihl, bit [3:0] in_ihl,
                                             bit [7:0] typ, bit [7:0] code,
                                             bit [7:0] proto, bit [15:0] sport,
                                             bit [15:0] dport, int pad);
        t_octet_q pkt;
        int oh;
        int ports_at;
        int total;
        oh       = ihl * 4;
        ports_at = oh + ICMP_HDR_BYTES + in_ihl * 4;
        total    = ports_at + 8;
        if (total < oh + ICMP_HDR_BYTES + IP_MIN_HDR_BYTES)
            total = oh + ICMP_HDR_BYTES + IP_MIN_HDR_BYTES;
        total += pad;
        for (int k = 0; k < total; k++) pkt.push_back(8'($urandom));
        pkt[0]          = {4'h4, ihl};
        pkt[oh]         = typ;
        pkt[oh + 1]     = code;
        pkt[oh + ICMP_HDR_BYTES] = {4'h4, in_ihl};
        pkt[oh + ICMP_HDR_BYTES + IP_PROTO_OFFSET] = proto;
        pkt[ports_at]     = sport[15:8];
        pkt[ports_at + 1] = sport[7:0];
        pkt[ports_at + 2] = dport[15:8];
        pkt[ports_at + 3] = dport[7:0];
        return pkt;
    endfunction

    function automatic bit [15:0] probe_dport();
        return sb.base_port + sb.probe_seq;
    endfunction

    // keep > 0 truncates the packet to that many bytes.
    task automatic send_reply(bit [3:0] ihl, bit [3:0] in_ihl, bit [7:0] typ,
                              bit [7:0] code, bit [7:0] proto, bit [15:0] sport,
                              bit [15:0] dport, int pad, int keep, bit ticks_inside);
        t_octet_q pkt;
        pkt = build_reply(ihl, in_ihl, typ, code, proto, sport, dport, pad);
        if (keep > 0 && keep < pkt.size()) pkt = pkt[0:keep - 1];
        send_packet(pkt, ticks_inside);
    endtask

    // Mostly well-formed replies for the current probe; a share with wrong
    // ports, odd header lengths, other types or truncation.
    task automatic random_reply();
        bit [3:0]  ihl;
        bit [3:0]  in_ihl;
        bit [7:0]  typ;
        bit [7:0]  code;
        bit [7:0]  proto;
        bit [15:0] sport;
        bit [15:0] dport;
        int        keep;
        ihl    = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd5;
        in_ihl = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd5;
        case ($urandom_range(0, 5))
            0, 5: begin typ = TYPE_TIME_EXCEEDED; code = CODE_INTRANS; end
            1:    begin typ = TYPE_DEST_UNREACH;  code = CODE_PORT;    end
            2:    begin typ = TYPE_DEST_UNREACH;  code = 8'($urandom); end
            3:    begin typ = TYPE_TIME_EXCEEDED; code = 8'($urandom); end
            default: begin typ = 8'($urandom); code = 8'($urandom); end
        endcase
        proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_UDP;
        sport = sb.src_port;
        dport = probe_dport();
        if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1)) sport ^= 16'd1 << $urandom_range(0, 15);
            else                      dport ^= 16'd1 << $urandom_range(0, 15);
        end
        keep = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 48) : 0;
        send_reply(ihl, in_ihl, typ, code, proto, sport, dport, $urandom_range(0, 16),
                   keep, $urandom_range(0, 9) == 0);
    endtask

    task automatic random_noise();
        t_octet_q pkt;
        repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
        send_packet(pkt, $urandom_range(0, 3) == 0);
    endtask

    // New register set between phases, extremes included.
    task automatic reconfigure();
        bit [31:0] v;
        case ($urandom_range(0, 2))
            0: v = 32'h0;
            1: v = 32'hFFFF;
            default: v = $urandom;
        endcase
        write_reg(REG_SRC_PORT, v);
        case ($urandom_range(0, 3))
            0: v = 32'h0;
            1: v = 32'hFFFF;
            2: v = RST_BASE_PORT;
            default: v = $urandom;
        endcase
        write_reg(REG_BASE_PORT, v);
        case ($urandom_range(0, 2))
            0: v = 32'h0;
            1: v = 32'hFFFF;
            default: v = $urandom;
        endcase
        write_reg(REG_PROBE_SEQ, v);
        case ($urandom_range(0, 4))
            0: v = 32'd1;
            1: v = 32'hFFFF_FFFF;
            2: v = $urandom_range(2, 8);
            3: v = $urandom_range(9, 40);
            default: v = $urandom;
        endcase
        write_reg(REG_TIMEOUT, v);
    endtask

    initial begin
        t_octet_q pkt;
        int       n_packets;
        sb         = new(PKT_LIMIT);
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = REQ_BYTE;
        i_pkt_byte = '0;
        i_is_last  = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_SRC_PORT;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // Reset defaults first: a matching time-exceeded for base port 33434.
        send_reply(4'd5, 4'd5, TYPE_TIME_EXCEEDED, CODE_INTRANS, PROTO_UDP, sb.src_port,
                   probe_dport(), 0, 0, 1'b0);
        wait_idle();
        // Ports at the top of their range; base + seq wraps to zero.
        write_reg(REG_SRC_PORT, 32'hFFFF);
        write_reg(REG_BASE_PORT, 32'hFFFF);
        write_reg(REG_PROBE_SEQ, 32'h1);
        write_reg(REG_TIMEOUT, 32'd2);
        // Packet too short for an ICMP header: ignored, type and code zero.
        send_item(REQ_BYTE, 8'h45, 1'b1);
        // Two ticks reach the timeout.
        send_tick();
        send_tick();
        // Port unreachable from the destination, then another unreachable code.
        send_reply(4'd5, 4'd5, TYPE_DEST_UNREACH, CODE_PORT, PROTO_UDP, sb.src_port,
                   probe_dport(), 2, 0, 1'b0);
        send_reply(4'd5, 4'd5, TYPE_DEST_UNREACH, 8'd1, PROTO_UDP, sb.src_port,
                   probe_dport(), 0, 0, 1'b0);
        // Time exceeded during reassembly: not in transit, so ignored.
        send_reply(4'd5, 4'd5, TYPE_TIME_EXCEEDED, 8'd1, PROTO_UDP, sb.src_port,
                   probe_dport(), 0, 0, 1'b0);
        // An ignored packet leaves the tick count alone.
        send_tick();
        send_item(REQ_BYTE, 8'hFF, 1'b1);
        send_tick();
        // Tick in the middle of a packet; the capture carries on around it.
        pkt = build_reply(4'd6, 4'd7, TYPE_DEST_UNREACH, CODE_PORT, PROTO_UDP, sb.src_port,
                          probe_dport(), 3);
        foreach (pkt[k]) begin
            if (k == 10) send_tick();
            send_item(REQ_BYTE, pkt[k], k == pkt.size() - 1);
        end
        // Header lengths below the minimum: capture points overlap.
        send_reply(4'd2, 4'd1, TYPE_TIME_EXCEEDED, CODE_INTRANS, PROTO_UDP, sb.src_port,
                   probe_dport(), 0, 0, 1'b0);
        send_reply(4'd0, 4'd0, TYPE_DEST_UNREACH, CODE_PORT, PROTO_UDP, sb.src_port,
                   probe_dport(), 0, 0, 1'b0);
        // Largest outer header length with a long quoted header.
        send_reply(4'd15, 4'd12, TYPE_TIME_EXCEEDED, CODE_INTRANS, PROTO_UDP, sb.src_port,
                   probe_dport(), 0, 0, 1'b0);
        // Overlong packet: bytes past the buffer are dropped.
        send_reply(4'd5, 4'd5, TYPE_DEST_UNREACH, CODE_PORT, PROTO_UDP, sb.src_port,
                   probe_dport(), PKT_LIMIT, 0, 1'b0);
        wait_idle();
        // Zero timeout: every tick times out.
        write_reg(REG_TIMEOUT, 32'd0);
        send_tick();
        send_tick();
        wait_idle();

        // ---- pressure: long consumer stall with a verdict per tick ----
        write_reg(REG_TIMEOUT, 32'd1);
        hold_request = 1'b1;
        wait (!hold_request);
        repeat (30) send_tick();
        // producer waits for the backlog to drain completely
        wait_idle();

        // ---- random part ----
        n_packets = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (n_packets % 20 == 0) begin
                wait_idle();
                reconfigure();
            end
            sender_gaps = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0:       random_noise();
                1:       repeat ($urandom_range(1, 4)) send_tick();
                default: random_reply();
            endcase
            n_packets++;
        end

        // ---- closing stretch, no idling anywhere ----
        wait_idle();
        calm = 1'b1;
        write_reg(REG_TIMEOUT, 32'd3);
        repeat (3) random_reply();
        repeat (4) send_tick();
        wait_idle();

        sb.flush_check();
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
